@@ rtl/core/mctrm_pkg.sv @@
package mctrm_pkg;

    localparam int CORES      = 4;
    localparam int RING_DEPTH = 512;
    localparam int SLOTS      = CORES * RING_DEPTH;
    localparam int CORE_W     = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int RING_W     = $clog2(RING_DEPTH);
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int LIMIT_W    = 12;

    typedef enum logic [1:0] {
        K_EMIT  = 2'd0,
        K_CLEAR = 2'd1,
        K_START = 2'd2,
        K_NEXT  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  source_core;
        logic [31:0] category_bits;
        logic [15:0] event_code;
        logic [63:0] arg_zero;
        logic [63:0] arg_one;
        logic [63:0] arg_two;
        logic [63:0] arg_three;
        logic [63:0] stamp_now;
        logic [11:0] record_limit;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [63:0] relative_time;
        logic [1:0]  record_core;
        logic [4:0]  category_index;
        logic [15:0] record_event;
        logic [63:0] out_arg_zero;
        logic [63:0] out_arg_one;
        logic [63:0] out_arg_two;
        logic [63:0] out_arg_three;
    } t_out;

    // lowest set bit index, 31 when none below bit 31
    function automatic logic [4:0] low_bit(input logic [31:0] w);
        logic [4:0] r;
        r = 5'd31;
        for (int i = 30; i >= 0; i--) begin
            if (w[i]) r = 5'(i);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/mctrm_if.sv @@
interface mctrm_in_if;
    logic            valid;
    logic            ready;
    mctrm_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mctrm_out_if;
    logic            valid;
    logic            ready;
    mctrm_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/multi_core_trace_ring_merge.sv @@
// Steps: dump start walks each core through address, read wait and compare; dump next
// does the same walk, then reads the lowest-stamped record (no read wait when none
// remains) and writes the result; it writes at once when the limit is spent.
// Throughput: one request at a time; the single time-store read port and shared 64-bit
// comparator set the pace. A waiting result stalls only the next dump-next output step.
// Reset: i_rst_n synchronous active low clears counts, cursors, base and limit.
module multi_core_trace_ring_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mctrm_in_if.sink           i_req,
    mctrm_out_if.source        o_res
);
    localparam int CW = mctrm_pkg::CORE_W;
    localparam int SW = mctrm_pkg::SLOT_W;
    localparam int RW = mctrm_pkg::RING_W;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_CMP, S_RD, S_RD2, S_OUT} t_state;

    // ring stores
    logic [63:0]  time_mem [mctrm_pkg::SLOTS];
    logic [22:0]  meta_mem [mctrm_pkg::SLOTS];
    logic [255:0] pay_mem  [mctrm_pkg::SLOTS];

    t_state       r_state;
    logic [63:0]  r_count [mctrm_pkg::CORES];
    logic [63:0]  r_pos   [mctrm_pkg::CORES];
    logic [63:0]  r_end   [mctrm_pkg::CORES];
    logic [63:0]  r_base;
    logic [11:0]  r_left;
    logic         r_start;
    logic [CW-1:0] r_core;
    logic [CW-1:0] r_best;
    logic         r_have;
    logic [63:0]  r_best_ts;
    logic         r_rd_ok;
    logic [63:0]  r_ts_q;
    logic [22:0]  r_meta_q;
    logic [255:0] r_pay_q;
    logic [SW-1:0] r_raddr;
    logic         r_ovalid;
    mctrm_pkg::t_out r_odata;

    logic [CW-1:0] w_emit_core;
    logic [SW-1:0] w_waddr;
    logic          w_acc;
    logic [63:0]   w_n;
    logic          w_live;
    logic [SW-1:0] w_scan_addr;
    logic          w_out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_odata;
    // output register can take a new result
    assign w_out_free  = !r_ovalid || o_res.ready;

    assign w_emit_core = CW'(32'(i_req.data.source_core) % mctrm_pkg::CORES);
    assign w_waddr = SW'({w_emit_core, r_count[w_emit_core][RW-1:0]});

    // live record count for the core being scanned, capped at the ring depth
    assign w_n = (r_count[r_core] < 64'(mctrm_pkg::RING_DEPTH))
               ? r_count[r_core] : 64'(mctrm_pkg::RING_DEPTH);
    assign w_live = r_start ? (w_n != 64'd0) : (r_pos[r_core] < r_end[r_core]);
    assign w_scan_addr = r_start ? SW'({r_core, RW'(r_count[r_core] - w_n)})
                                 : SW'({r_core, r_pos[r_core][RW-1:0]});

    // ring writes and registered reads
    always_ff @(posedge i_clk) begin
        if (w_acc && i_req.data.kind == mctrm_pkg::K_EMIT) begin
            time_mem[w_waddr] <= i_req.data.stamp_now;
            meta_mem[w_waddr] <= {2'(w_emit_core), mctrm_pkg::low_bit(i_req.data.category_bits),
                                  i_req.data.event_code};
            pay_mem[w_waddr]  <= {i_req.data.arg_three, i_req.data.arg_two,
                                  i_req.data.arg_one, i_req.data.arg_zero};
        end
        r_ts_q   <= time_mem[r_raddr];
        r_meta_q <= meta_mem[r_raddr];
        r_pay_q  <= pay_mem[r_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            for (int c = 0; c < mctrm_pkg::CORES; c++) begin
                r_count[c] <= '0; r_pos[c] <= '0; r_end[c] <= '0;
            end
            r_base   <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
            r_start  <= 1'b0;
            r_core   <= '0;
            r_best   <= '0;
            r_have   <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (r_ovalid && o_res.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_req.data.kind)
                            mctrm_pkg::K_EMIT:
                                r_count[w_emit_core] <= r_count[w_emit_core] + 64'd1;
                            mctrm_pkg::K_CLEAR:
                                for (int c = 0; c < mctrm_pkg::CORES; c++) r_count[c] <= '0;
                            mctrm_pkg::K_START: begin
                                if (i_req.data.record_limit == 12'd0 ||
                                    32'(i_req.data.record_limit) > mctrm_pkg::SLOTS)
                                    r_left <= 12'(mctrm_pkg::SLOTS);
                                else
                                    r_left <= i_req.data.record_limit;
                                r_start <= 1'b1; r_core <= '0; r_have <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_start <= 1'b0; r_core <= '0; r_have <= 1'b0;
                                r_state <= (r_left != 12'd0) ? S_SCAN : S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_raddr <= w_scan_addr;
                    r_rd_ok <= w_live;
                    if (r_start) begin
                        r_pos[r_core] <= r_count[r_core] - w_n;
                        r_end[r_core] <= r_count[r_core];
                    end
                    r_state <= S_WAIT;
                end
                S_WAIT: r_state <= S_CMP;
                S_CMP: begin
                    // shared compare unit: one core per pass
                    if (r_rd_ok && (!r_have || r_ts_q < r_best_ts)) begin
                        r_have <= 1'b1; r_best <= r_core; r_best_ts <= r_ts_q;
                    end
                    if (32'(r_core) == mctrm_pkg::CORES - 1) begin
                        if (r_start) begin
                            r_base  <= (r_rd_ok && (!r_have || r_ts_q < r_best_ts)) ? r_ts_q
                                     : (r_have ? r_best_ts : 64'd0);
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else begin
                        r_core  <= r_core + CW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_RD: begin
                    r_raddr <= SW'({r_best, r_pos[r_best][RW-1:0]});
                    r_state <= r_have ? S_RD2 : S_OUT;
                end
                S_RD2: r_state <= S_OUT;
                S_OUT: begin
                    // wait here until the output register is free
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        if (r_have && r_left != 12'd0) begin
                            r_odata <= {1'b1, r_best_ts - r_base, r_meta_q[22:21],
                                        r_meta_q[20:16], r_meta_q[15:0],
                                        r_pay_q[63:0], r_pay_q[127:64],
                                        r_pay_q[191:128], r_pay_q[255:192]};
                            r_pos[r_best] <= r_pos[r_best] + 64'd1;
                            r_left        <= r_left - 12'd1;
                        end else begin
                            r_odata <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no new request while the sequencer is busy
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("ready while busy");
    // a found result always consumes limit
    a_found_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free && r_have && r_left != 12'd0)
        |=> (r_left == $past(r_left) - 12'd1))
        else $error("limit not consumed");
    // result only leaves through the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT)) else $error("stray result");

endmodule
